FILE: rtl/twa_pkg.sv
// ----------------------------------------------------------------------------
// twa_pkg
// Shared types and widths for the time span window aggregator.
// ----------------------------------------------------------------------------
package twa_pkg;

  localparam int TS_W     = 47;
  localparam int SMP_W    = 32;
  localparam int OCNT_W   = 7;
  localparam int OSUM_W   = 38;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SPAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_EVICT  = 2'd1;

  typedef struct packed {
    logic [TS_W-1:0]         ts;
    logic signed [SMP_W-1:0] smp;
    logic                    pres;
  } entry_t;

  typedef struct packed {
    logic push;
    logic drop;
  } ring_cmd_t;

endpackage

FILE: rtl/twa_if.sv
// ----------------------------------------------------------------------------
// twa_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface twa_in_if;
  logic                             valid;
  logic                             ready;
  logic [twa_pkg::TS_W-1:0]         timestamp;
  logic signed [twa_pkg::SMP_W-1:0] sample;
  logic                             sample_present;

  modport source (output valid, timestamp, sample, sample_present, input ready);
  modport sink   (input valid, timestamp, sample, sample_present, output ready);
endinterface

interface twa_out_if;
  logic                              valid;
  logic                              ready;
  logic [twa_pkg::OCNT_W-1:0]        entry_count;
  logic signed [twa_pkg::OSUM_W-1:0] window_sum;
  logic signed [twa_pkg::SMP_W-1:0]  window_average;
  logic                              average_valid;
  logic signed [twa_pkg::SMP_W-1:0]  window_maximum;
  logic                              maximum_valid;
  logic signed [twa_pkg::SMP_W-1:0]  first_value;
  logic                              first_valid;
  logic [twa_pkg::OCNT_W-1:0]        valid_count;

  modport source (output valid, entry_count, window_sum, window_average, average_valid,
                  window_maximum, maximum_valid, first_value, first_valid, valid_count,
                  input ready);
  modport sink   (input valid, entry_count, window_sum, window_average, average_valid,
                  window_maximum, maximum_valid, first_value, first_valid, valid_count,
                  output ready);
endinterface

FILE: rtl/twa_ring.sv
// ----------------------------------------------------------------------------
// twa_ring
// Entry memory with head pointer and fill level; one registered read port.
// ----------------------------------------------------------------------------
module twa_ring #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  twa_pkg::ring_cmd_t cmd,
  input  twa_pkg::entry_t    wr_entry,
  input  logic [CW-1:0]      rd_off,
  output twa_pkg::entry_t    rd_entry,
  output logic [CW-1:0]      fill
);

  localparam int PW = CW + 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  twa_pkg::entry_t mem [DEPTH];
  twa_pkg::entry_t rd_entry_r;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [AW-1:0]   head_inc, wr_addr, rd_addr;
  logic [PW-1:0]   wr_sum, rd_sum;
  logic            full;

  assign full = (fill_r == DEPTH_C);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  always_comb begin
    wr_sum = PW'(head_r) + PW'(fill_r);
    if (wr_sum >= DEPTH_P) wr_sum = wr_sum - DEPTH_P;
    rd_sum = PW'(head_r) + PW'(rd_off);
    if (rd_sum >= DEPTH_P) rd_sum = rd_sum - DEPTH_P;
  end

  assign wr_addr = full ? head_r : wr_sum[AW-1:0];
  assign rd_addr = rd_sum[AW-1:0];

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (cmd.push) begin
      if (full) head_nxt = head_inc;
      else      fill_nxt = fill_r + CW'(1);
    end else if (cmd.drop) begin
      head_nxt = head_inc;
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) mem[wr_addr] <= wr_entry;
    rd_entry_r <= mem[rd_addr];
  end

  assign rd_entry = rd_entry_r;
  assign fill     = fill_r;

endmodule

FILE: rtl/twa_div.sv
// ----------------------------------------------------------------------------
// twa_div
// Iterative restoring divider, signed dividend by unsigned divisor,
// one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module twa_div #(
  parameter int DW = 40,
  parameter int NW = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic [NW-1:0]        divisor,
  output logic                 done,
  output logic signed [DW-1:0] quotient
);

  localparam int KW = $clog2(DW + 1);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [NW:0]   rem_r, rem_nxt;
  logic [NW-1:0] dsr_r;
  logic          neg_r, busy_r, done_r;
  logic [KW-1:0] cnt_r;
  logic [NW:0]   trial;

  always_comb begin
    trial   = {rem_r[NW-1:0], quo_r[DW-1]};
    quo_nxt = {quo_r[DW-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt    = trial - {1'b0, dsr_r};
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= KW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - KW'(1);
        if (cnt_r == KW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
      rem_r <= '0;
      dsr_r <= divisor;
      neg_r <= dividend[DW-1];
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

FILE: rtl/time_span_window_aggregator.sv
// Flow from input accept to result valid: accept, then in time mode one age check per
// eviction plus a final one, then the scan of the remaining entries, then the divider
// (start, a quotient of 33 + clog2(WINDOW_DEPTH + 1) bits, done), then the result load.
// Throughput: one word in flight; input is ready again once the result is loaded.
// Reset (synchronous, rst_n low): ring empty, window_span 0, time eviction on.
// ----------------------------------------------------------------------------
// time_span_window_aggregator
// Sequencer for the timestamped ring: push, age eviction when enabled, scan, average.
// ----------------------------------------------------------------------------
module time_span_window_aggregator #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  twa_in_if.sink                            in_ch,
  twa_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [twa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [twa_pkg::TS_W-1:0]          cfg_wdata
);

  localparam int CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = twa_pkg::SMP_W + CW + 1;
  localparam int TW    = twa_pkg::TS_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVRD  = 3'd1;
  localparam logic [2:0] S_EVCHK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DIVS  = 3'd4;
  localparam logic [2:0] S_DIVW  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;

  logic [twa_pkg::TS_W-1:0]          span_r;
  logic                              tevict_r;
  logic [twa_pkg::TS_W-1:0]          ts_r;
  twa_pkg::ring_cmd_t                cmd;
  twa_pkg::entry_t                   wr_entry, rd_entry;
  logic [CW-1:0]                     rd_off, fill, idx_r;
  logic                              pend_r, issue, in_acc;
  logic signed [SUM_W-1:0]           sum_r;
  logic [CW-1:0]                     nval_r;
  logic signed [twa_pkg::SMP_W-1:0]  max_r, first_r;
  logic                              found_r;
  logic signed [TW-1:0]              age;
  logic                              evict;
  logic                              div_start, div_done;
  logic signed [SUM_W-1:0]           quot;
  logic                              ovalid_r;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign wr_entry.ts   = in_ch.timestamp;
  assign wr_entry.smp  = in_ch.sample;
  assign wr_entry.pres = in_ch.sample_present;

  assign age   = $signed({1'b0, ts_r}) - $signed({1'b0, rd_entry.ts});
  assign evict = (state_r == S_EVCHK) && (fill != '0) && (age > $signed({1'b0, span_r}));
  assign issue = (state_r == S_SCAN) && (idx_r < fill);

  assign cmd.push  = in_acc;
  assign cmd.drop  = evict;
  assign rd_off    = (state_r == S_SCAN) ? idx_r : '0;
  assign div_start = (state_r == S_DIVS);

  twa_ring #(.DEPTH(WINDOW_DEPTH)) u_ring (
    .clk, .rst_n, .cmd, .wr_entry, .rd_off, .rd_entry, .fill
  );

  twa_div #(.DW(SUM_W), .NW(CW)) u_div (
    .clk, .rst_n, .start(div_start), .dividend(sum_r), .divisor(nval_r),
    .done(div_done), .quotient(quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = tevict_r ? S_EVRD : S_SCAN;
      S_EVRD:  state_nxt = S_EVCHK;
      S_EVCHK: state_nxt = evict ? S_EVRD : S_SCAN;
      S_SCAN:  if (!issue && !pend_r) state_nxt = S_DIVS;
      S_DIVS:  state_nxt = S_DIVW;
      S_DIVW:  if (div_done) state_nxt = S_OUT;
      S_OUT:   if (!ovalid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      span_r   <= '0;
      tevict_r <= 1'b1;
      ovalid_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= issue;
      if (cfg_we) begin
        unique case (cfg_index)
          twa_pkg::CFG_WINDOW_SPAN: span_r   <= cfg_wdata;
          twa_pkg::CFG_TIME_EVICT:  tevict_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state_r == S_OUT && (!ovalid_r || out_ch.ready)) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ts_r    <= in_ch.timestamp;
      idx_r   <= '0;
      sum_r   <= '0;
      nval_r  <= '0;
      max_r   <= '0;
      first_r <= '0;
      found_r <= 1'b0;
    end
    if (issue) idx_r <= idx_r + CW'(1);
    if (pend_r && rd_entry.pres) begin
      sum_r  <= sum_r + SUM_W'(rd_entry.smp);
      nval_r <= nval_r + CW'(1);
      if (!found_r) begin
        first_r <= rd_entry.smp;
        max_r   <= rd_entry.smp;
        found_r <= 1'b1;
      end else if (rd_entry.smp > max_r) begin
        max_r <= rd_entry.smp;
      end
    end
    if (state_r == S_OUT && (!ovalid_r || out_ch.ready)) begin
      out_ch.entry_count    <= twa_pkg::OCNT_W'(fill);
      out_ch.window_sum     <= twa_pkg::OSUM_W'(sum_r);
      out_ch.window_average <= found_r ? twa_pkg::SMP_W'(quot) : '0;
      out_ch.average_valid  <= found_r;
      out_ch.window_maximum <= max_r;
      out_ch.maximum_valid  <= found_r;
      out_ch.first_value    <= first_r;
      out_ch.first_valid    <= found_r;
      out_ch.valid_count    <= twa_pkg::OCNT_W'(nval_r);
    end
  end

  assign out_ch.valid = ovalid_r;

endmodule

FILE: rtl/twa_checker.sv
// ----------------------------------------------------------------------------
// twa_checker
// Port-level checks for the time span window aggregator.
// ----------------------------------------------------------------------------
module twa_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [twa_pkg::OSUM_W-1:0] window_sum,
  input logic                              average_valid,
  input logic                              maximum_valid,
  input logic                              first_valid,
  input logic [twa_pkg::OCNT_W-1:0]        valid_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  a_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (average_valid == maximum_valid) && (maximum_valid == first_valid))
    else $error("valid flags disagree");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !average_valid |-> (window_sum == '0) && (valid_count == '0))
    else $error("nonzero sum with no valid samples");

endmodule

bind time_span_window_aggregator twa_checker u_twa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .window_sum    (out_ch.window_sum),
  .average_valid (out_ch.average_valid),
  .maximum_valid (out_ch.maximum_valid),
  .first_valid   (out_ch.first_valid),
  .valid_count   (out_ch.valid_count)
);

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the time span window aggregator. Words go to the block with
// random gaps, and results are checked against a predictor that keeps its
// own copy of the ring. It runs over several span and eviction settings and
// includes one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH      = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 2000;
  localparam int DRAIN_WAIT = 300;

  typedef struct {
    logic [twa_pkg::TS_W-1:0]          ts;
    logic signed [twa_pkg::SMP_W-1:0]  smp;
    logic                              pres;
  } word_t;

  typedef struct {
    logic [twa_pkg::OCNT_W-1:0]        entry_count;
    logic signed [twa_pkg::OSUM_W-1:0] window_sum;
    logic signed [twa_pkg::SMP_W-1:0]  window_average;
    logic                              average_valid;
    logic signed [twa_pkg::SMP_W-1:0]  window_maximum;
    logic                              maximum_valid;
    logic signed [twa_pkg::SMP_W-1:0]  first_value;
    logic                              first_valid;
    logic [twa_pkg::OCNT_W-1:0]        valid_count;
  } summary_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [twa_pkg::CFG_IDX_W-1:0] cfg_index = twa_pkg::CFG_WINDOW_SPAN;
  logic [twa_pkg::TS_W-1:0] cfg_wdata = '0;

  twa_in_if  in_ch ();
  twa_out_if out_ch ();

  time_span_window_aggregator #(.WINDOW_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  word_t    word_q[$];
  summary_t summary_q[$];
  int       errors = 0;
  bit       calm = 0;
  int       hold_req = 0;

  // predictor state
  logic [twa_pkg::TS_W-1:0]         ring_ts [DEPTH];
  logic signed [twa_pkg::SMP_W-1:0] ring_smp [DEPTH];
  logic                             ring_pres [DEPTH];
  int                               ring_head = 0;
  int                               ring_fill = 0;
  logic [twa_pkg::TS_W-1:0]         span_reg = '0;
  logic                             evict_en = 1'b1;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.timestamp = '0;
    in_ch.sample = '0;
    in_ch.sample_present = 1'b0;
    out_ch.ready = 1'b0;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic summary_t window_summary(input word_t w);
    summary_t r;
    longint sum, avg, age;
    int nvalid, p;
    logic signed [twa_pkg::SMP_W-1:0] maxv, firstv;
    bit found;
    sum = 0; avg = 0; nvalid = 0; maxv = 0; firstv = 0; found = 0;
    if (ring_fill >= DEPTH) begin
      ring_head = (ring_head + 1) % DEPTH;
      ring_fill--;
    end
    p = (ring_head + ring_fill) % DEPTH;
    ring_ts[p] = w.ts;
    ring_smp[p] = w.smp;
    ring_pres[p] = w.pres;
    ring_fill++;
    if (evict_en) begin
      while (ring_fill > 0) begin
        age = longint'({17'd0, w.ts}) - longint'({17'd0, ring_ts[ring_head]});
        if (age > longint'({17'd0, span_reg})) begin
          ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
        end else break;
      end
    end
    for (int i = 0; i < ring_fill; i++) begin
      p = (ring_head + i) % DEPTH;
      if (ring_pres[p]) begin
        sum += longint'(ring_smp[p]);
        if (!found) begin
          firstv = ring_smp[p];
          maxv = ring_smp[p];
          found = 1;
        end else if (ring_smp[p] > maxv) begin
          maxv = ring_smp[p];
        end
        nvalid++;
      end
    end
    if (nvalid > 0) avg = sum / nvalid;
    r.entry_count = ring_fill[twa_pkg::OCNT_W-1:0];
    r.window_sum = sum[twa_pkg::OSUM_W-1:0];
    r.window_average = avg[twa_pkg::SMP_W-1:0];
    r.average_valid = found;
    r.window_maximum = maxv;
    r.maximum_valid = found;
    r.first_value = firstv;
    r.first_valid = found;
    r.valid_count = nvalid[twa_pkg::OCNT_W-1:0];
    return r;
  endfunction

  // input side: acceptance at the rising edge, new word at the falling edge
  bit took = 0;
  int in_gap = 0;

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      word_t w;
      w.ts = in_ch.timestamp;
      w.smp = in_ch.sample;
      w.pres = in_ch.sample_present;
      summary_q.push_back(window_summary(w));
      took = 1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || took)) begin
      took = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (word_q.size() > 0) begin
        word_t w;
        w = word_q.pop_front();
        in_ch.timestamp <= w.ts;
        in_ch.sample <= w.smp;
        in_ch.sample_present <= w.pres;
        in_ch.valid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 16);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side
  int out_stall = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req > 0) begin
        out_stall = hold_req;
        hold_req = 0;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) out_stall = $urandom_range(1, 16);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (summary_q.size() == 0) begin
        report("unexpected word", out_ch.entry_count, 0);
      end else begin
        summary_t e;
        e = summary_q.pop_front();
        if (out_ch.entry_count !== e.entry_count)
          report("entry_count", out_ch.entry_count, e.entry_count);
        if (out_ch.window_sum !== e.window_sum)
          report("window_sum", out_ch.window_sum, e.window_sum);
        if (out_ch.window_average !== e.window_average)
          report("window_average", out_ch.window_average, e.window_average);
        if (out_ch.average_valid !== e.average_valid)
          report("average_valid", out_ch.average_valid, e.average_valid);
        if (out_ch.window_maximum !== e.window_maximum)
          report("window_maximum", out_ch.window_maximum, e.window_maximum);
        if (out_ch.maximum_valid !== e.maximum_valid)
          report("maximum_valid", out_ch.maximum_valid, e.maximum_valid);
        if (out_ch.first_value !== e.first_value)
          report("first_value", out_ch.first_value, e.first_value);
        if (out_ch.first_valid !== e.first_valid)
          report("first_valid", out_ch.first_valid, e.first_valid);
        if (out_ch.valid_count !== e.valid_count)
          report("valid_count", out_ch.valid_count, e.valid_count);
      end
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [twa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [twa_pkg::TS_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == twa_pkg::CFG_WINDOW_SPAN) span_reg = data;
    else if (idx == twa_pkg::CFG_TIME_EVICT) evict_en = data[0];
  endtask

  task automatic wait_idle();
    while (word_q.size() > 0 || in_ch.valid || summary_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic add_word(input logic [twa_pkg::TS_W-1:0] ts,
                          input logic [twa_pkg::SMP_W-1:0] smp, input logic pres);
    word_t w;
    w.ts = ts;
    w.smp = smp;
    w.pres = pres;
    word_q.push_back(w);
  endtask

  logic [twa_pkg::TS_W-1:0] cur_ts = '0;

  task automatic add_random(input int n, input int step_max);
    logic [twa_pkg::SMP_W-1:0] s;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 2) cur_ts = twa_pkg::TS_W'({$urandom, $urandom});
      else if (k < 6) cur_ts = cur_ts - $urandom_range(1, 40);
      else cur_ts = cur_ts + $urandom_range(0, step_max);
      k = $urandom_range(0, 19);
      if (k == 0) s = 32'h7fff_ffff;
      else if (k == 1) s = 32'h8000_0000;
      else if (k < 5) s = $urandom_range(0, 8) - 4;
      else s = $urandom;
      add_word(cur_ts, s, $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: span 0, eviction on
    add_word('0, 32'h7fff_ffff, 1'b1);
    add_word('0, 32'h8000_0000, 1'b1);
    add_word('0, 32'h0000_0000, 1'b0);
    add_word('0, 32'hffff_ffff, 1'b1);
    add_word(47'd5, 32'h0001_0000, 1'b1);
    add_word(47'd3, 32'h0002_0000, 1'b1);
    add_word(47'd5, 32'h0003_0000, 1'b0);
    add_word({twa_pkg::TS_W{1'b1}}, 32'h1234_5678, 1'b1);
    add_word({twa_pkg::TS_W{1'b1}}, 32'h8000_0001, 1'b1);
    add_word(47'd0, 32'h0000_0001, 1'b1);
    add_word(47'd0, 32'h0000_0000, 1'b0);
    add_word(47'd1, 32'h7fff_ffff, 1'b1);
    cur_ts = 47'd1;
    add_random(250, 2);
    wait_idle();

    // widest span: the ring fills and drops its oldest entries
    write_reg(twa_pkg::CFG_WINDOW_SPAN, {twa_pkg::TS_W{1'b1}});
    for (int i = 0; i < 70; i++) add_word(47'd100 + i, 32'h7fff_ffff, 1'b1);
    for (int i = 0; i < 70; i++) add_word(47'd200 + i, 32'h8000_0000, 1'b1);
    hold_req = LONG_HOLD;
    add_random(200, 1000);
    wait_idle();

    write_reg(twa_pkg::CFG_WINDOW_SPAN, twa_pkg::TS_W'($urandom_range(5, 60)));
    add_random(300, 4);
    wait_idle();

    write_reg(twa_pkg::CFG_TIME_EVICT, twa_pkg::TS_W'(0));
    write_reg(twa_pkg::CFG_WINDOW_SPAN, twa_pkg::TS_W'($urandom_range(0, 3)));
    add_random(200, 50);
    wait_idle();

    write_reg(twa_pkg::CFG_TIME_EVICT, twa_pkg::TS_W'(1));
    write_reg(twa_pkg::CFG_WINDOW_SPAN, twa_pkg::TS_W'({$urandom, $urandom}));
    add_random(100, 1 << 30);
    wait_idle();

    calm = 1;
    write_reg(twa_pkg::CFG_WINDOW_SPAN, twa_pkg::TS_W'(30));
    add_random(150, 2);
    wait_idle();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
